/* sv/dfs_pkg.sv */
// Shared constants for the depth-first search block: field widths,
// command codes and parameter defaults. No dependencies.
package dfs_pkg;

   localparam int NODES_DEFAULT       = 16;
   localparam int STACK_DEPTH_DEFAULT = 256;

   localparam int CMD_W   = 1;
   localparam int NODE_W  = 4;
   localparam int NBR_W   = 16;
   localparam int VNODE_W = 4;

   localparam logic [CMD_W-1:0] CMD_LOAD_ROW = 1'b0;
   localparam logic [CMD_W-1:0] CMD_RUN      = 1'b1;

endpackage

/* sv/dfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dfs_pick.sv */
// Highest-set-bit finder over the pending neighbour mask.
// No dependencies.
module dfs_pick #(
   parameter int NODES = 16
) (
   input  logic [NODES-1:0]         mask,
   output logic                     found,
   output logic [$clog2(NODES)-1:0] index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = 0; i < NODES; i++) begin
         if (mask[i]) begin
            found = 1'b1;
            index = ($clog2(NODES))'(i);
         end
      end
   end

endmodule

/* sv/dfs_graph_traversal.sv */
// Top level of the depth-first search engine; uses dfs_pkg, dfs_ram, dfs_pick.
// Holds the control sequencer and the adjacency, stack and visit-order RAMs.
//
// A load request (command 0) writes one adjacency row. A run request
// (command 1) walks the graph from the given node with an explicit stack held
// in RAM, then streams the visited nodes in visit order; the overflow flag on
// every result tells whether any stack push was dropped, so results start only
// after the walk ends. Each pop runs POP and CHECK; a newly visited node then
// runs LOAD to read its adjacency row and SCAN to push its unvisited
// neighbours one at a time. Each result passes through EMIT_RD, EMIT_LD and
// EMIT_OUT, waiting in EMIT_OUT while the output is stalled. Requests are
// stalled for the whole run. Adjacency rows read as zero until written.
module dfs_graph_traversal
   import dfs_pkg::*;
#(
   parameter int NODES       = NODES_DEFAULT,
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [NODE_W-1:0]  req_node,
   input  logic [NBR_W-1:0]   req_neighbours,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VNODE_W-1:0] rsp_visited_node,
   output logic               rsp_last,
   output logic               rsp_overflow
);

   localparam int NW  = $clog2(NODES);
   localparam int CW  = $clog2(NODES + 1);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_CHECK,
      ST_LOAD,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [SPW-1:0]     sp_ff, sp_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [NW-1:0]      emit_idx_ff, emit_idx_in;
   logic [NW-1:0]      cur_ff, cur_in;
   logic [NODES-1:0]   visited_ff, visited_in;
   logic [NODES-1:0]   mask_ff, mask_in;
   logic [NODES-1:0]   row_valid_ff, row_valid_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VNODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               adj_we;
   logic [NW-1:0]      adj_wa;
   logic [NODES-1:0]   adj_wd;
   logic [NODES-1:0]   adj_rd;
   logic               stk_we;
   logic [SAW-1:0]     stk_wa;
   logic [NW-1:0]      stk_wd;
   logic [SAW-1:0]     stk_ra;
   logic [NW-1:0]      stk_rd;
   logic               ord_we;
   logic [NW-1:0]      ord_wa;
   logic [NW-1:0]      ord_rd;
   logic               pick_found;
   logic [NW-1:0]      pick_idx;
   logic               req_take;
   logic               node_ok;

   dfs_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_wa),
      .wr_data (adj_wd),
      .rd_addr (stk_rd),
      .rd_data (adj_rd)
   );

   dfs_ram #(.WIDTH(NW), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   dfs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_wa),
      .wr_data (stk_rd),
      .rd_addr (emit_idx_ff),
      .rd_data (ord_rd)
   );

   dfs_pick #(.NODES(NODES)) u_pick (
      .mask  (mask_ff),
      .found (pick_found),
      .index (pick_idx)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign req_take         = req_valid && !req_stall;
   assign node_ok          = (32'(req_node) < NODES);
   assign stk_ra           = SAW'(sp_ff - SPW'(1));
   assign ord_wa           = count_ff[NW-1:0];
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_visited_node = rsp_node_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      count_in     = count_ff;
      emit_idx_in  = emit_idx_ff;
      cur_in       = cur_ff;
      visited_in   = visited_ff;
      mask_in      = mask_ff;
      row_valid_in = row_valid_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      adj_we       = 1'b0;
      adj_wa       = NW'(req_node);
      adj_wd       = NODES'(req_neighbours);
      stk_we       = 1'b0;
      stk_wa       = '0;
      stk_wd       = NW'(req_node);
      ord_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && node_ok) begin
               if (req_command == CMD_LOAD_ROW) begin
                  adj_we               = 1'b1;
                  row_valid_in[adj_wa] = 1'b1;
               end else begin
                  stk_we     = 1'b1;
                  sp_in      = SPW'(1);
                  count_in   = '0;
                  visited_in = '0;
                  ovf_in     = 1'b0;
                  state_in   = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               emit_idx_in = '0;
               state_in    = ST_EMIT_RD;
            end else begin
               sp_in    = sp_ff - SPW'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (visited_ff[stk_rd]) begin
               state_in = ST_POP;
            end else begin
               visited_in[stk_rd] = 1'b1;
               ord_we             = 1'b1;
               count_in           = count_ff + CW'(1);
               cur_in             = stk_rd;
               state_in           = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mask_in  = row_valid_ff[cur_ff] ? (adj_rd & ~visited_ff) : '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!pick_found) begin
               state_in = ST_POP;
            end else begin
               mask_in[pick_idx] = 1'b0;
               if (sp_ff == SPW'(STACK_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  stk_we = 1'b1;
                  stk_wa = sp_ff[SAW-1:0];
                  stk_wd = pick_idx;
                  sp_in  = sp_ff + SPW'(1);
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = VNODE_W'(ord_rd);
            rsp_last_in  = ((CW'(emit_idx_ff) + CW'(1)) == count_ff);
            rsp_ovf_in   = ovf_ff;
            state_in     = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + NW'(1);
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff    <= count_in;
      emit_idx_ff <= emit_idx_in;
      cur_ff      <= cur_in;
      visited_ff  <= visited_in;
      mask_ff     <= mask_in;
      ovf_ff      <= ovf_in;
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

endmodule
